// File: rtl/spdq_pkg.sv
// Package for the stable priority deferred queue.
// Holds the entry and result types and the operation, status and register codes.
// No dependencies.
package spdq_pkg;

  localparam int ACT_W = 8;
  localparam int HDL_W = 16;
  localparam int PRI_W = 8;
  localparam int ST_W  = 2;

  localparam logic       OP_ENQ   = 1'b0;
  localparam logic       OP_DRAIN = 1'b1;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_NULL = 2'd2;

  localparam logic REG_FORWARD = 1'b0;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef struct packed {
    logic [PRI_W-1:0] priority_v;
    logic [HDL_W-1:0] handle;
    logic [ACT_W-1:0] action;
  } entry_t;

  typedef struct packed {
    logic             last;
    entry_t           entry;
    logic             has_entry;
    logic [ST_W-1:0]  status;
  } res_t;

endpackage

// File: rtl/spdq_mem.sv
// Entry store of the stable priority deferred queue.
// One write port and one read port, read data registered.
// Depends on spdq_pkg.
module spdq_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  spdq_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output spdq_pkg::entry_t rd_data
);

  spdq_pkg::entry_t mem_r [DEPTH];
  spdq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/spdq_ctrl.sv
// Sequencer of the stable priority deferred queue.
// Runs enqueue, selection scans over the entry store and the output register.
// Depends on spdq_pkg and spdq_mem.
module spdq_ctrl #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int CW    = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         forward,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  spdq_pkg::entry_t             in_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output spdq_pkg::res_t               out_res
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TAIL, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    emit_r, emit_nxt;
  logic [AW-1:0]    scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pidx_r, pidx_nxt;
  logic             best_vld_r, best_vld_nxt;
  spdq_pkg::entry_t best_r, best_nxt;
  logic [AW-1:0]    best_idx_r, best_idx_nxt;
  logic [DEPTH-1:0] done_r, done_nxt;
  logic             out_vld_r, out_vld_nxt;
  spdq_pkg::res_t   out_r, out_nxt;

  logic             wr_en;
  logic             rd_en;
  spdq_pkg::entry_t rd_data;
  logic             in_take;
  logic             out_free;
  logic             cand_ok;
  logic [CW-1:0]    emit_inc;
  logic [CW-1:0]    count_dec;
  logic [AW-1:0]    scan_hi;
  logic             emit_last;

  spdq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_entry),
    .rd_en   (rd_en),
    .rd_addr (scan_r),
    .rd_data (rd_data)
  );

  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_take   = in_valid && in_ready;
  assign rd_en     = (state_r == S_SCAN);
  assign emit_inc  = emit_r + CW'(1);
  assign count_dec = count_r - CW'(1);
  assign scan_hi   = forward ? emit_r[AW-1:0] : count_dec[AW-1:0];
  assign emit_last = (emit_inc == count_r);
  assign cand_ok   = !done_r[pidx_r] &&
                     (!best_vld_r || (rd_data.priority_v > best_r.priority_v));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    emit_nxt     = emit_r;
    scan_nxt     = scan_r;
    pend_nxt     = rd_en;
    pidx_nxt     = scan_r;
    best_vld_nxt = best_vld_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    done_nxt     = done_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;
    wr_en        = 1'b0;

    if (pend_r && cand_ok) begin
      best_vld_nxt = 1'b1;
      best_nxt     = rd_data;
      best_idx_nxt = pidx_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          out_nxt      = '0;
          out_nxt.last = 1'b1;
          if (in_op == spdq_pkg::OP_ENQ) begin
            out_vld_nxt = 1'b1;
            if (in_entry.action == '0) begin
              out_nxt.status = spdq_pkg::ST_NULL;
            end else if (count_r == CW'(DEPTH)) begin
              out_nxt.status = spdq_pkg::ST_FULL;
            end else begin
              out_nxt.status = spdq_pkg::ST_OK;
              wr_en          = 1'b1;
              count_nxt      = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            out_vld_nxt    = 1'b1;
            out_nxt.status = spdq_pkg::ST_OK;
          end else begin
            state_nxt    = S_SCAN;
            done_nxt     = '0;
            emit_nxt     = '0;
            scan_nxt     = '0;
            best_vld_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (scan_r == scan_hi) begin
          state_nxt = S_TAIL;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      S_TAIL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt           = 1'b1;
          out_nxt.status        = spdq_pkg::ST_OK;
          out_nxt.has_entry     = 1'b1;
          out_nxt.entry         = best_r;
          out_nxt.last          = emit_last;
          done_nxt[best_idx_r]  = 1'b1;
          best_vld_nxt          = 1'b0;
          if (emit_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            emit_nxt  = emit_inc;
            scan_nxt  = forward ? emit_inc[AW-1:0] : '0;
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      emit_r     <= '0;
      scan_r     <= '0;
      pend_r     <= 1'b0;
      best_vld_r <= 1'b0;
      done_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      emit_r     <= emit_nxt;
      scan_r     <= scan_nxt;
      pend_r     <= pend_nxt;
      best_vld_r <= best_vld_nxt;
      done_r     <= done_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    pidx_r     <= pidx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

// File: rtl/stable_priority_deferred_queue.sv
// Top level of the stable priority deferred queue.
// Holds the configuration register and the stream packing; depends on spdq_pkg, spdq_ctrl.
//
// Usage:
//   in_*  : one item per handshake. in_tuser[0] = operation (0 enqueue, 1 drain),
//           in_tdata = action_code, user_handle, priority_req from bit 0 up.
//   out_* : result items; out_tlast marks the final result of an input item.
//   cfg_* : APB-style port, register forward_unsorted at byte address 0.
// Flow:
//   An enqueue's status item appears the cycle after acceptance, and
//   enqueues follow back to back while the receiver takes them.
//   A drain in priority order finds each result by one full scan of the
//   stored entries through the single read port of the entry memory. In
//   forward order each result is read, latched and emitted in turn. An
//   empty drain gives one result.
// Reset:
//   rst_n clears the entry count, the control state and forward_unsorted; the
//   memory is not cleared. No new item is taken during a drain.
// Stall:
//   A result waits in the output register while out_tready is low; the
//   sequencer may scan ahead but holds its next result until it is taken.
module stable_priority_deferred_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // action_code[7:0], user_handle[23:8], priority_req[31:24]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], has_entry[2], out_action[10:3],
                                  // out_handle[26:11], out_priority[34:27], zero[39:35]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [spdq_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [spdq_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [spdq_pkg::CFG_DW-1:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic             forward_r;
  logic             cfg_wr;
  logic             cfg_sel_fwd;
  spdq_pkg::entry_t in_entry;
  spdq_pkg::res_t   out_res;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_fwd = (cfg_paddr[2] == spdq_pkg::REG_FORWARD);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = cfg_sel_fwd ? {{(spdq_pkg::CFG_DW-1){1'b0}}, forward_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forward_r <= 1'b0;
    end else if (cfg_wr && cfg_sel_fwd) begin
      forward_r <= cfg_pwdata[0];
    end
  end

  assign in_entry.action     = in_tdata[7:0];
  assign in_entry.handle     = in_tdata[23:8];
  assign in_entry.priority_v = in_tdata[31:24];

  spdq_ctrl #(.DEPTH(QUEUE_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .forward   (forward_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_entry  (in_entry),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'b0, out_res.entry.priority_v, out_res.entry.handle,
                      out_res.entry.action, out_res.has_entry, out_res.status};
  assign out_tlast = out_res.last;

endmodule

// File: rtl/spdq_chk.sv
// Port checker for the stable priority deferred queue, bound to the top level.
// Watches the result channel only; depends on spdq_pkg and stable_priority_deferred_queue.
module spdq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != spdq_pkg::ST_OK) |-> !out_tdata[2] && out_tlast)
    else $error("rejected enqueue carries an entry or is not last");

  a_noentry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tlast && (out_tdata[39:3] == 37'd0))
    else $error("result without entry has payload or is not last");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= spdq_pkg::ST_NULL)
    else $error("undefined status code");

endmodule

bind stable_priority_deferred_queue spdq_chk u_spdq_chk (.*);

// File: test/tb_stable_priority_deferred_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for stable_priority_deferred_queue: streams enqueue and drain
// items, predicts every result item with a behavioral queue model and compares field by field.
// Depends on spdq_pkg and the stable_priority_deferred_queue RTL.
module tb_stable_priority_deferred_queue;

  localparam int DEPTH         = 32;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CAP    = 100000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 35;
  localparam int HOLD_CYCLES   = 400;
  localparam int TARGET_ITEMS  = 350;
  localparam int PRINT_CAP     = 40;
  localparam int CFG_AW        = spdq_pkg::CFG_AW;
  localparam int CFG_DW        = spdq_pkg::CFG_DW;

  localparam logic [CFG_AW-1:0] ADDR_FORWARD = CFG_AW'(4 * int'(spdq_pkg::REG_FORWARD));
  localparam logic [CFG_AW-1:0] ADDR_SPARE   = CFG_AW'(4 * (int'(spdq_pkg::REG_FORWARD) + 1));

  typedef struct {
    logic             op;
    spdq_pkg::entry_t ent;
  } offer_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata    = '0;  // action_code[7:0], user_handle[23:8], priority_req[31:24]
  logic [0:0]        in_tuser    = '0;  // operation[0]
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [39:0]       out_tdata;         // status[1:0], has_entry[2], out_action[10:3],
                                        // out_handle[26:11], out_priority[34:27], zero[39:35]
  logic              out_tlast;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  offer_t           offer_q[$];
  spdq_pkg::res_t   outcome_q[$];
  spdq_pkg::entry_t shelf[$];
  logic   fwd_mode      = 1'b0;
  logic   no_idle       = 1'b0;
  logic   hold_kick     = 1'b0;
  int     hold_left     = 0;
  int     cycle_count   = 0;
  int     err_count     = 0;
  int     n_offered     = 0;
  int     n_enq         = 0;
  int     n_drain       = 0;
  int     n_full        = 0;
  int     n_null        = 0;
  int     n_results     = 0;
  int     longest_drain = 0;

  stable_priority_deferred_queue #(.QUEUE_DEPTH(DEPTH)) u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void apply_queue_item(logic op, spdq_pkg::entry_t ent);
    spdq_pkg::res_t   r;
    spdq_pkg::entry_t pool[$];
    int               pick;
    r = '0;
    r.status = spdq_pkg::ST_OK;
    r.last = 1'b1;
    if (op == spdq_pkg::OP_ENQ) begin
      n_enq++;
      if (ent.action == '0) begin
        r.status = spdq_pkg::ST_NULL;
        n_null++;
      end else if (shelf.size() >= DEPTH) begin
        r.status = spdq_pkg::ST_FULL;
        n_full++;
      end else begin
        shelf.push_back(ent);
      end
      outcome_q.push_back(r);
    end else begin
      n_drain++;
      pool = shelf;
      if (pool.size() > longest_drain) longest_drain = pool.size();
      if (pool.size() == 0) outcome_q.push_back(r);
      // first of the highest priority keeps equal priorities in arrival order
      while (pool.size() > 0) begin
        pick = 0;
        if (!fwd_mode) begin
          for (int i = 1; i < pool.size(); i++)
            if (pool[i].priority_v > pool[pick].priority_v) pick = i;
        end
        r.has_entry = 1'b1;
        r.entry = pool[pick];
        r.last = (pool.size() == 1);
        outcome_q.push_back(r);
        pool.delete(pick);
      end
      shelf.delete();
    end
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    if (err_count < PRINT_CAP)
      $display("[%0t] result %0d %s: got 0x%0h, want 0x%0h", $time, n_results, what, got, want);
    err_count++;
  endtask

  task automatic check_result(logic [39:0] data, logic tlast);
    spdq_pkg::res_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch("arrived with nothing pending", data, '0);
    end else begin
      want = outcome_q.pop_front();
      n_results++;
      if (data[1:0] !== want.status) report_mismatch("status", data[1:0], want.status);
      if (data[2] !== want.has_entry) report_mismatch("has_entry", data[2], want.has_entry);
      if (data[10:3] !== want.entry.action)
        report_mismatch("action", data[10:3], want.entry.action);
      if (data[26:11] !== want.entry.handle)
        report_mismatch("handle", data[26:11], want.entry.handle);
      if (data[34:27] !== want.entry.priority_v)
        report_mismatch("priority", data[34:27], want.entry.priority_v);
      if (data[39:35] !== '0) report_mismatch("padding", data[39:35], '0);
      if (tlast !== want.last) report_mismatch("tlast", tlast, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) apply_queue_item(in_tuser[0], spdq_pkg::entry_t'(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (offer_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tuser <= offer_q[0].op;
          in_tdata <= offer_q[0].ent;
          offer_q.delete(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result(out_tdata, out_tlast);
      out_tready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (hold_kick && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_stable_priority_deferred_queue: done, errors");
    $finish;
  end

  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    while ((offer_q.size() != 0 || in_tvalid || outcome_q.size() != 0) && waited < SETTLE_CAP)
    begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    rdata = cfg_prdata;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_forward(logic mode);
    logic [CFG_DW-1:0] rd;
    settle();
    cfg_access(1'b1, ADDR_FORWARD, ($urandom & ~32'h1) | CFG_DW'(mode), rd);
    fwd_mode = mode;
    cfg_access(1'b1, ADDR_SPARE, $urandom, rd);
    cfg_access(1'b0, ADDR_FORWARD, '0, rd);
    if (rd[0] !== mode) report_mismatch("forward_unsorted readback", rd, mode);
  endtask

  task automatic push_item(logic op, logic [spdq_pkg::ACT_W-1:0] act,
                           logic [spdq_pkg::HDL_W-1:0] hdl,
                           logic [spdq_pkg::PRI_W-1:0] pri);
    offer_t o;
    o.op = op;
    o.ent.action = act;
    o.ent.handle = hdl;
    o.ent.priority_v = pri;
    offer_q.push_back(o);
    n_offered++;
  endtask

  task automatic push_directed_set();
    push_item(spdq_pkg::OP_ENQ, 8'h00, 16'hFFFF, 8'hFF);
    push_item(spdq_pkg::OP_ENQ, 8'hFF, 16'hFFFF, 8'hFF);
    push_item(spdq_pkg::OP_ENQ, 8'h01, 16'h0000, 8'h00);
    push_item(spdq_pkg::OP_ENQ, 8'h55, 16'hAAAA, 8'h80);
    push_item(spdq_pkg::OP_ENQ, 8'hAA, 16'h5555, 8'h80);
    push_item(spdq_pkg::OP_ENQ, 8'h33, 16'h0F0F, 8'hFF);
    push_item(spdq_pkg::OP_DRAIN, 8'hFF, 16'hFFFF, 8'hFF);
  endtask

  task automatic push_run(int n_items, bit ties, int null_pct);
    logic [spdq_pkg::PRI_W-1:0] pri;
    for (int i = 0; i < n_items; i++) begin
      if (ties)
        pri = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(252, 255));
      else
        pri = 8'($urandom);
      push_item(spdq_pkg::OP_ENQ,
                ($urandom_range(0, 99) < null_pct) ? 8'h00 : 8'($urandom_range(1, 255)),
                16'($urandom), pri);
    end
    push_item(spdq_pkg::OP_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic push_fill();
    for (int i = 0; i < DEPTH + 3; i++)
      push_item(spdq_pkg::OP_ENQ, 8'($urandom_range(1, 255)), 16'($urandom),
                8'($urandom_range(0, 7)));
    push_item(spdq_pkg::OP_ENQ, 8'h00, 16'($urandom), 8'($urandom));
    push_item(spdq_pkg::OP_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic push_noise(int n_items);
    for (int i = 0; i < n_items; i++)
      push_item(($urandom_range(0, 99) < 30) ? spdq_pkg::OP_DRAIN : spdq_pkg::OP_ENQ,
                ($urandom_range(0, 99) < 20) ? 8'h00 : 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    int roll;
    int phase;
    phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_item(spdq_pkg::OP_DRAIN, 8'hFF, 16'hFFFF, 8'hFF);
    push_directed_set();
    push_item(spdq_pkg::OP_DRAIN, 8'h00, 16'h0000, 8'h00);
    set_forward(1'b1);
    push_directed_set();
    push_item(spdq_pkg::OP_ENQ, 8'h80, 16'h8001, 8'h7F);
    push_item(spdq_pkg::OP_DRAIN, 8'h00, 16'h0000, 8'h00);
    set_forward(1'b0);
    push_fill();
    settle();

    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    push_run(DEPTH, 1'b1, 5);
    settle();

    no_idle = 1'b1;
    push_run(12, 1'b1, 5);
    push_run(20, 1'b0, 5);
    push_run(1, 1'b0, 0);
    settle();
    no_idle = 1'b0;

    while (n_offered < TARGET_ITEMS) begin
      phase++;
      if (phase % 6 == 0) set_forward(~fwd_mode);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        push_fill();
      end else if (roll < 22) begin
        push_noise($urandom_range(3, 8));
      end else begin
        push_run($urandom_range(1, 10), $urandom_range(0, 1), 5);
      end
    end

    settle();
    while (outcome_q.size() != 0) begin
      report_mismatch("never arrived", '0, outcome_q[0]);
      outcome_q.delete(0);
    end
    $display("Run covered %0d enqueues (%0d full, %0d null rejects) and %0d drains,",
             n_enq, n_full, n_null, n_drain);
    $display("%0d result items checked in both drain orders; longest drain %0d entries.",
             n_results, longest_drain);
    if (err_count == 0) begin
      $display("tb_stable_priority_deferred_queue: done, clean");
    end else begin
      $display("tb_stable_priority_deferred_queue: done, errors");
    end
    $finish;
  end

endmodule
